/* design/dmht_pkg.sv */
// shared widths, command codes and slot entry type for the hash table
package dmht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CAP_W       = ADDR_W + 1;
	localparam int VALUE_W     = 32;
	localparam int HASH_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int CMD_W       = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(TABLE_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
	} slot_entry_t;

endpackage

/* design/dmht_mod.sv */
// restoring remainder unit: hash modulo capacity, one dividend bit per cycle
module dmht_mod
	import dmht_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [CAP_W-1:0]  divisor,
	output logic              done,
	output logic [ADDR_W-1:0] remainder
);

	localparam int CNT_W = $clog2(HASH_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [CAP_W-1:0]  dvs_q;
	logic [ADDR_W-1:0] rem_q;

	logic [CAP_W-1:0]  trial;
	logic [CAP_W-1:0]  trial_sub;
	logic [ADDR_W-1:0] rem_next;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		trial     = {rem_q, dvd_q[HASH_W-1]};
		trial_sub = trial - dvs_q;
		if (trial >= dvs_q) begin
			rem_next = trial_sub[ADDR_W-1:0];
		end else begin
			rem_next = trial[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(HASH_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* design/direct_mapped_hash_table.sv */
// direct-mapped hash table with a 16-bit bsd checksum key hash
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | start & !busy           | key_byte key_last key_empty command value_in
//  result   | done (one-cycle strobe) | value_out found slot_index key_hash entry_count
//  config   | cfg_write               | cfg_data (table_capacity)
//
// a key byte that is not last is taken without raising busy, so bytes stream
// back to back. a last or empty-key transaction holds busy through the bit-serial
// modulo unit, its done flag, one slot memory read and one read-modify-write.
// the result strobe comes in the same cycle that busy falls; the receiver cannot stall.
// after reset the slot memory is swept once to clear valid bits, with busy high
// throughout; config writes are taken during the sweep.
module direct_mapped_hash_table
	import dmht_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [BYTE_W-1:0]  key_byte,
	input  logic               key_last,
	input  logic               key_empty,
	input  logic [CMD_W-1:0]   command,
	input  logic [VALUE_W-1:0] value_in,
	// configuration
	input  logic               cfg_write,
	input  logic [CAP_W-1:0]   cfg_data,
	// results
	output logic               done,
	output logic [VALUE_W-1:0] value_out,
	output logic               found,
	output logic [ADDR_W-1:0]  slot_index,
	output logic [HASH_W-1:0]  key_hash,
	output logic [CAP_W-1:0]   entry_count
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_WRITE
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [CAP_W-1:0]   cap_q;
	logic [HASH_W-1:0]  run_hash_q;
	logic [HASH_W-1:0]  hash_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [VALUE_W-1:0] val_q;
	logic [ADDR_W-1:0]  slot_q;
	logic [CAP_W-1:0]   count_q;

	logic               done_q;
	logic [VALUE_W-1:0] value_out_q;
	logic               found_q;
	logic [ADDR_W-1:0]  slot_index_q;
	logic [HASH_W-1:0]  key_hash_q;
	logic [CAP_W-1:0]   entry_count_q;

	// slot memory: one read port, one write port, registered read data
	slot_entry_t        slot_mem [TABLE_DEPTH];
	slot_entry_t        rd_entry_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	slot_entry_t        mem_wdata;

	logic               accept;
	logic [HASH_W-1:0]  mixed;
	logic [HASH_W-1:0]  final_hash;
	logic [CAP_W-1:0]   eff_cap;
	logic               div_start;
	logic               div_done;
	logic [ADDR_W-1:0]  div_rem;

	logic               was_valid;
	logic [VALUE_W-1:0] old_value;
	logic [CAP_W-1:0]   count_next;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// bsd checksum step: rotate right by one, add the byte
	assign mixed      = {run_hash_q[0], run_hash_q[HASH_W-1:1]} + HASH_W'(key_byte);
	assign final_hash = key_empty ? '0 : mixed;

	// capacity zero acts as one, above the depth saturates
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (cap_q > CAP_W'(TABLE_DEPTH)) begin
			eff_cap = CAP_W'(TABLE_DEPTH);
		end else begin
			eff_cap = cap_q;
		end
	end

	assign div_start = accept && (key_last || key_empty);

	dmht_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (final_hash),
		.divisor   (eff_cap),
		.done      (div_done),
		.remainder (div_rem)
	);

	// read-modify-write of the addressed slot
	always_comb begin
		was_valid  = rd_entry_q.valid;
		old_value  = was_valid ? rd_entry_q.value : '0;
		count_next = count_q;
		mem_we     = 1'b0;
		mem_waddr  = slot_q;
		mem_wdata  = rd_entry_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we          = 1'b1;
				mem_waddr       = clr_q;
				mem_wdata.valid = 1'b0;
			end
			ST_WRITE: begin
				case (cmd_q)
					CMD_INSERT: begin
						mem_we          = 1'b1;
						mem_wdata.valid = 1'b1;
						mem_wdata.value = val_q;
						if (!was_valid) begin
							count_next = count_q + 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (was_valid) begin
							mem_we          = 1'b1;
							mem_wdata.valid = 1'b0;
							count_next      = count_q - 1'b1;
						end
					end
					default: begin
						// lookup and the unused code leave the table alone
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_entry_q <= slot_mem[slot_q];
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write) begin
			cap_q <= cfg_data;
		end
	end

	// control sequencer and registered result outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			run_hash_q <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (key_last || key_empty) begin
							run_hash_q <= '0;
							hash_q     <= final_hash;
							cmd_q      <= command;
							val_q      <= value_in;
							state_q    <= ST_DIV;
						end else begin
							run_hash_q <= mixed;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						slot_q  <= div_rem;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// memory read of slot_q lands in rd_entry_q
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					count_q       <= count_next;
					done_q        <= 1'b1;
					value_out_q   <= old_value;
					found_q       <= was_valid;
					slot_index_q  <= slot_q;
					key_hash_q    <= hash_q;
					entry_count_q <= count_next;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign value_out   = value_out_q;
	assign found       = found_q;
	assign slot_index  = slot_index_q;
	assign key_hash    = key_hash_q;
	assign entry_count = entry_count_q;

endmodule
